FILE: hw/rtl/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg: shared types and constants for the sorted grant table
// Table depth, entry layout, command and status codes.
// ----------------------------------------------------------------------------
package sgt_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned CapW       = 7;
  // key, granter, grantee, mask, expiry, revoked, origin
  localparam int unsigned EntryW     = 64 * 5 + 32 + 1;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_REVOKE   = 2'd1,
    CMD_FIND     = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_FULL      = 3'd2,
    ST_DUP       = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] granter;
    logic [63:0] grantee;
    logic [31:0] mask;
    logic [63:0] expiry;
    logic        revoked;
    logic [63:0] origin;
  } entry_t;

  localparam logic [CapW-1:0] CapReset = CapW'(TableDepth);
endpackage

FILE: hw/rtl/sgt_ram.sv
// ----------------------------------------------------------------------------
// sgt_ram: generic single-port-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sgt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/sorted_grant_table_mask_query_top.sv
// ----------------------------------------------------------------------------
// sorted_grant_table_mask_query_top: sorted grant table with mask query
// Holds grants sorted by key in one RAM; register, revoke, find, mask query.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | slave     | in_tvalid/in_tready    | in_tdata (command record)
//  out_    | master    | out_tvalid/out_tready  | out_tdata (result record)
//  cfg_    | APB       | psel/penable/pready    | capacity_limit at 0x0
//
// One command at a time. A command walks the table one entry per cycle
// through the registered RAM read port: search stops at the first
// key not below the given one, a query scans all count entries, an insert
// then shifts entries up from the top, reading each entry and then writing
// it one place up.
// Reset empties the table (count to zero); RAM contents are not cleared.
// The output register holds a result until taken; the next command is
// accepted only after that transfer.
module sorted_grant_table_mask_query_top
  import sgt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] command, [65:2] grant_key, [129:66] granter, [193:130] grantee,
  // [225:194] grant_mask, [289:226] expiry_time, [353:290] provenance,
  // [385:354] base_bits, [449:386] now_time, [455:450] zero
  input  logic [455:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] status, [34:3] effective_mask, [98:35] found_granter,
  // [162:99] found_grantee, [194:163] found_mask, [258:195] found_expiry,
  // [259] found_revoked, [323:260] found_provenance, [327:324] zero
  output logic [327:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_SHIFT, S_WRITE, S_REVOKE, S_DONE
  } state_t;

  localparam int unsigned CntW1 = CntW;

  state_t            state_r;
  logic [CapW-1:0]   cap_r;
  logic [CntW1-1:0]  count_r;
  logic [CntW1-1:0]  idx_r;     // scan address driven to the RAM read port
  logic              rd_vld_r;  // RAM data for idx_r-1 valid this cycle
  logic [CntW1-1:0]  pos_r;     // insertion / match position
  logic [CntW1-1:0]  sh_r;      // shift destination
  logic [455:0]      cmd_r;
  logic [2:0]        status_r;
  logic [31:0]       acc_r;
  entry_t            found_r;
  logic              ovld_r;

  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  entry_t            wdata, rdata;

  sgt_ram #(.Width(EntryW), .Depth(TableDepth)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  cmd_t        c_cmd;
  logic [63:0] c_key, c_granter, c_grantee, c_expiry, c_prov, c_now;
  logic [31:0] c_gmask, c_base;
  assign c_cmd     = cmd_t'(cmd_r[1:0]);
  assign c_key     = cmd_r[65:2];
  assign c_granter = cmd_r[129:66];
  assign c_grantee = cmd_r[193:130];
  assign c_gmask   = cmd_r[225:194];
  assign c_expiry  = cmd_r[289:226];
  assign c_prov    = cmd_r[353:290];
  assign c_base    = cmd_r[385:354];
  assign c_now     = cmd_r[449:386];

  logic [CntW1-1:0] cap_eff;
  assign cap_eff = (cap_r > CapW'(TableDepth)) ? CntW1'(TableDepth) : CntW1'(cap_r);

  assign in_tready  = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {4'd0, found_r.origin, found_r.revoked, found_r.expiry,
                       found_r.mask, found_r.grantee, found_r.granter, acc_r, status_r};
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {25'd0, cap_r};

  // Read address: next entry in scan, entry below shift destination, or matched entry on revoke.
  always_comb begin
    raddr = idx_r[IdxW-1:0];
    if (state_r == S_SHIFT) raddr = IdxW'(sh_r - CntW1'(1));
    else if (state_r == S_REVOKE) raddr = pos_r[IdxW-1:0];
  end

  entry_t new_e;
  always_comb begin
    new_e.key     = c_key;
    new_e.granter = c_granter;
    new_e.grantee = c_grantee;
    new_e.mask    = c_gmask;
    new_e.expiry  = c_expiry;
    new_e.revoked = 1'b0;
    new_e.origin  = (c_prov != 64'd0) ? c_prov : c_key;
  end

  // Shift step: rd_vld_r means rdata holds entry sh_r-1 read last cycle.
  always_comb begin
    we    = 1'b0;
    waddr = sh_r[IdxW-1:0];
    wdata = rdata;
    unique case (state_r)
      S_SHIFT:  we = rd_vld_r;
      S_WRITE:  begin we = 1'b1; waddr = pos_r[IdxW-1:0]; wdata = new_e; end
      S_REVOKE: begin
        we = rd_vld_r; waddr = pos_r[IdxW-1:0]; wdata = rdata; wdata.revoked = 1'b1;
      end
      default: ;
    endcase
  end

  logic live;
  assign live = (rdata.grantee == c_grantee) && !rdata.revoked &&
                ((rdata.expiry == 64'd0) || (rdata.expiry > c_now));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cap_r    <= CapReset;
      count_r  <= '0;
      ovld_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
        cap_r <= cfg_pwdata[CapW-1:0];
      if (ovld_r && out_tready) ovld_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r    <= in_tdata;
            idx_r    <= '0;
            rd_vld_r <= 1'b0;
            status_r <= ST_OK;
            acc_r    <= '0;
            found_r  <= '0;
            state_r  <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          // Issue next address; evaluate data of entry idx_r-1.
          if (c_cmd == CMD_REGISTER && (c_key == 64'd0 || c_grantee == 64'd0)) begin
            status_r <= ST_ZERO;
            state_r  <= S_DONE;
          end else if (c_cmd == CMD_REGISTER && count_r >= cap_eff) begin
            status_r <= ST_FULL;
            state_r  <= S_DONE;
          end else if (c_cmd == CMD_QUERY && c_grantee == 64'd0) begin
            acc_r   <= c_base;
            state_r <= S_DONE;
          end else if (rd_vld_r && c_cmd == CMD_QUERY) begin
            if (idx_r >= count_r) begin
              acc_r   <= c_base | acc_r | (live ? rdata.mask : 32'd0);
              state_r <= S_DONE;
            end else begin
              if (live) acc_r <= acc_r | rdata.mask;
              idx_r <= idx_r + CntW1'(1);
            end
          end else if (rd_vld_r && rdata.key >= c_key) begin
            rd_vld_r <= 1'b0;
            pos_r <= idx_r - CntW1'(1);
            if (rdata.key == c_key) begin
              unique case (c_cmd)
                CMD_REGISTER: begin status_r <= ST_DUP; state_r <= S_DONE; end
                CMD_REVOKE:   state_r <= S_REVOKE;
                default:      begin found_r <= rdata; state_r <= S_DONE; end
              endcase
            end else if (c_cmd == CMD_REGISTER) begin
              sh_r <= count_r; state_r <= S_SHIFT;
            end else begin
              status_r <= ST_NOT_FOUND; state_r <= S_DONE;
            end
          end else if (idx_r >= count_r) begin
            // End of table reached without a stop.
            rd_vld_r <= 1'b0;
            if (c_cmd == CMD_QUERY) begin
              acc_r <= c_base | acc_r; state_r <= S_DONE;
            end else if (c_cmd == CMD_REGISTER) begin
              pos_r <= count_r; sh_r <= count_r; state_r <= S_SHIFT;
            end else begin
              status_r <= ST_NOT_FOUND; state_r <= S_DONE;
            end
          end else begin
            idx_r <= idx_r + CntW1'(1); rd_vld_r <= 1'b1;
          end
        end
        S_SHIFT: begin
          // Move entry sh_r-1 up to sh_r until pos_r is reached.
          if (sh_r == pos_r) begin
            state_r <= S_WRITE;
            rd_vld_r <= 1'b0;
          end else if (rd_vld_r) begin
            sh_r <= sh_r - CntW1'(1);
            rd_vld_r <= 1'b0;
          end else begin
            rd_vld_r <= 1'b1;
          end
        end
        S_WRITE: begin
          count_r <= count_r + CntW1'(1);
          state_r <= S_DONE;
        end
        S_REVOKE: begin
          if (rd_vld_r) begin rd_vld_r <= 1'b0; state_r <= S_DONE; end
          else rd_vld_r <= 1'b1;
        end
        S_DONE: begin
          if (c_cmd != CMD_QUERY) acc_r <= '0;
          if (!ovld_r) begin ovld_r <= 1'b1; state_r <= S_IDLE; end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW1'(TableDepth)) else $error("count beyond depth");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("ready with pending result");
  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> $past(state_r) == S_WRITE)
    else $error("count moved outside insert");
endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the sorted grant table with mask query
// Drives command records over the input stream, predicts every result with a
// behavioral copy of the table, and checks each result transfer field by field.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sgt_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [63:0] now_time;
    logic [31:0] base_bits;
    logic [63:0] provenance;
    logic [63:0] expiry_time;
    logic [31:0] grant_mask;
    logic [63:0] grantee;
    logic [63:0] granter;
    logic [63:0] grant_key;
    cmd_t        command;
  } grant_cmd_t;

  typedef struct packed {
    logic [63:0] found_provenance;
    logic        found_revoked;
    logic [63:0] found_expiry;
    logic [31:0] found_mask;
    logic [63:0] found_grantee;
    logic [63:0] found_granter;
    logic [31:0] effective_mask;
    status_t     status;
  } grant_result_t;

  // Behavioral grant table plus the queue of results still owed by the block.
  class grant_table_tracker;
    entry_t        table_q[$];
    int unsigned   cap_limit;
    grant_result_t pending_results[$];
    int unsigned   errors;

    function void clear();
      table_q.delete();
      cap_limit = TableDepth;
      pending_results.delete();
      errors = 0;
    endfunction

    function int find_pos(logic [63:0] key);
      foreach (table_q[i])
        if (table_q[i].key == key) return i;
      return -1;
    endfunction

    function void note_command(grant_cmd_t c);
      grant_result_t r;
      entry_t e;
      int pos;
      int unsigned cap;
      r = '0;
      r.status = ST_OK;
      cap = (cap_limit < TableDepth) ? cap_limit : TableDepth;
      case (c.command)
        CMD_REGISTER: begin
          if (c.grant_key == 0 || c.grantee == 0) r.status = ST_ZERO;
          else if (table_q.size() >= cap) r.status = ST_FULL;
          else if (find_pos(c.grant_key) >= 0) r.status = ST_DUP;
          else begin
            e.key = c.grant_key;
            e.granter = c.granter;
            e.grantee = c.grantee;
            e.mask = c.grant_mask;
            e.expiry = c.expiry_time;
            e.revoked = 1'b0;
            e.origin = (c.provenance != 0) ? c.provenance : c.grant_key;
            pos = table_q.size();
            foreach (table_q[i])
              if (table_q[i].key > c.grant_key && pos == table_q.size()) pos = i;
            table_q.insert(pos, e);
          end
        end
        CMD_REVOKE: begin
          pos = find_pos(c.grant_key);
          if (pos >= 0) table_q[pos].revoked = 1'b1;
          else r.status = ST_NOT_FOUND;
        end
        CMD_FIND: begin
          pos = find_pos(c.grant_key);
          if (pos >= 0) begin
            r.found_granter = table_q[pos].granter;
            r.found_grantee = table_q[pos].grantee;
            r.found_mask = table_q[pos].mask;
            r.found_expiry = table_q[pos].expiry;
            r.found_revoked = table_q[pos].revoked;
            r.found_provenance = table_q[pos].origin;
          end else r.status = ST_NOT_FOUND;
        end
        default: begin
          r.effective_mask = c.base_bits;
          if (c.grantee != 0)
            foreach (table_q[i])
              if (table_q[i].grantee == c.grantee && !table_q[i].revoked &&
                  (table_q[i].expiry == 0 || table_q[i].expiry > c.now_time))
                r.effective_mask |= table_q[i].mask;
        end
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(grant_result_t got, realtime t);
      grant_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", t, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status exp %0d act %0d", t, want.status, got.status); errors++;
      end
      if (got.effective_mask != want.effective_mask) begin
        $display("%0t: effective_mask exp %h act %h", t, want.effective_mask,
                 got.effective_mask); errors++;
      end
      if (got.found_granter != want.found_granter) begin
        $display("%0t: found_granter exp %h act %h", t, want.found_granter,
                 got.found_granter); errors++;
      end
      if (got.found_grantee != want.found_grantee) begin
        $display("%0t: found_grantee exp %h act %h", t, want.found_grantee,
                 got.found_grantee); errors++;
      end
      if (got.found_mask != want.found_mask) begin
        $display("%0t: found_mask exp %h act %h", t, want.found_mask, got.found_mask);
        errors++;
      end
      if (got.found_expiry != want.found_expiry) begin
        $display("%0t: found_expiry exp %h act %h", t, want.found_expiry,
                 got.found_expiry); errors++;
      end
      if (got.found_revoked != want.found_revoked) begin
        $display("%0t: found_revoked exp %b act %b", t, want.found_revoked,
                 got.found_revoked); errors++;
      end
      if (got.found_provenance != want.found_provenance) begin
        $display("%0t: found_provenance exp %h act %h", t, want.found_provenance,
                 got.found_provenance); errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [455:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [327:0] out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [1:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  grant_table_tracker tracker = new();
  int unsigned send_idle_pct = 0;   // chance in 100 of a sender gap
  int unsigned recv_stall_pct = 0;  // chance in 100 of a receiver stall
  int unsigned hold_off_cycles = 0; // long receiver hold-off, counted below
  int unsigned quiet_cycles = 0;

  // Keys and grantees from small pools, so duplicates, hits and mask
  // accumulation occur often.
  logic [63:0] key_pool[16];
  logic [63:0] grantee_pool[6];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_grant_table_mask_query_top DUT (.*);

  // Receiver: stall at random, or hold off for a counted stretch.
  always @(posedge clk) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result transfer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result(grant_result_t'(out_tdata[323:0]), $realtime);
  end

  // Watchdog: count cycles with no transfer on either stream.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL sorted_grant_table_mask_query_top");
      $finish;
    end
  end

  // Hold tvalid after a transfer; the next call or drain() decides its value.
  task automatic send_command(grant_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, c};
    do @(posedge clk); while (!in_tready);
    tracker.note_command(c);
  endtask

  task automatic write_capacity(int unsigned value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 2'd0;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    tracker.cap_limit = value & 7'h7f;
  endtask

  // Wait for all results, then let the block settle before a register write.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (2 * TableDepth + 8) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic grant_cmd_t random_command();
    grant_cmd_t c;
    int unsigned pick;
    c = '0;
    c.command = cmd_t'($urandom_range(3));
    pick = $urandom_range(99);
    c.grant_key = (pick < 85) ? key_pool[$urandom_range(15)] :
                  (pick < 90) ? 64'd0 : rand64();
    c.granter = rand64();
    pick = $urandom_range(99);
    c.grantee = (pick < 85) ? grantee_pool[$urandom_range(5)] :
                (pick < 90) ? 64'd0 : rand64();
    c.grant_mask = $urandom;
    pick = $urandom_range(3);
    c.expiry_time = (pick == 0) ? 64'd0 : (pick == 1) ? rand64() :
                    64'($urandom_range(1000));
    c.provenance = ($urandom_range(3) == 0) ? 64'd0 : rand64();
    c.base_bits = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
    c.now_time = ($urandom_range(1) == 0) ? 64'($urandom_range(1000)) : rand64();
    return c;
  endfunction

  function automatic grant_cmd_t make_cmd(cmd_t op, logic [63:0] key,
                                          logic [63:0] who, logic [63:0] expiry,
                                          logic [63:0] prov, logic [63:0] now);
    grant_cmd_t c;
    c = '0;
    c.command = op;
    c.grant_key = key;
    c.granter = ~key;
    c.grantee = who;
    c.grant_mask = key[31:0] ^ 32'hA5A5_5A5A;
    c.expiry_time = expiry;
    c.provenance = prov;
    c.base_bits = 32'h0000_0100;
    c.now_time = now;
    return c;
  endfunction

  initial begin
    int unsigned phase_items;
    tracker.clear();
    foreach (key_pool[i]) key_pool[i] = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                        (i == 1) ? 64'd1 : rand64();
    foreach (grantee_pool[i]) grantee_pool[i] = (i == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                                rand64();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero key/grantee, duplicates, extremes, revoke twice,
    // absent keys, expiry boundaries, zero grantee in a query.
    send_command(make_cmd(CMD_REGISTER, 64'd0, 64'd7, 0, 0, 0));
    send_command(make_cmd(CMD_REGISTER, 64'd5, 64'd0, 0, 0, 0));
    send_command(make_cmd(CMD_REGISTER, 64'hFFFF_FFFF_FFFF_FFFF, 64'd7, 0, 0, 0));
    send_command(make_cmd(CMD_REGISTER, 64'd1, 64'd7, 64'd100, 64'd0, 0));
    send_command(make_cmd(CMD_REGISTER, 64'd50, 64'd7, 64'd200, 64'hFFFF_FFFF_FFFF_FFFF, 0));
    send_command(make_cmd(CMD_REGISTER, 64'd50, 64'd9, 0, 0, 0));
    send_command(make_cmd(CMD_FIND, 64'd1, 0, 0, 0, 0));
    send_command(make_cmd(CMD_FIND, 64'd50, 0, 0, 0, 0));
    send_command(make_cmd(CMD_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0));
    send_command(make_cmd(CMD_FIND, 64'd0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_FIND, 64'd2, 0, 0, 0, 0));
    send_command(make_cmd(CMD_QUERY, 0, 64'd7, 0, 0, 64'd99));
    send_command(make_cmd(CMD_QUERY, 0, 64'd7, 0, 0, 64'd100));
    send_command(make_cmd(CMD_QUERY, 0, 64'd7, 0, 0, 64'd200));
    send_command(make_cmd(CMD_QUERY, 0, 64'd0, 0, 0, 64'd0));
    send_command(make_cmd(CMD_REVOKE, 64'd50, 0, 0, 0, 0));
    send_command(make_cmd(CMD_REVOKE, 64'd50, 0, 0, 0, 0));
    send_command(make_cmd(CMD_REVOKE, 64'd0, 0, 0, 0, 0));
    send_command(make_cmd(CMD_REVOKE, 64'd3, 0, 0, 0, 0));
    send_command(make_cmd(CMD_FIND, 64'd50, 0, 0, 0, 0));
    send_command(make_cmd(CMD_QUERY, 0, 64'd7, 0, 0, 64'd0));
    drain();

    // Capacity below count: every registration is refused as full.
    write_capacity(0);
    send_command(make_cmd(CMD_REGISTER, 64'd9, 64'd7, 0, 0, 0));
    send_command(make_cmd(CMD_FIND, 64'd1, 0, 0, 0, 0));
    drain();
    write_capacity(127);

    // Random phases with different idle mixes and capacities.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (phase == 0) hold_off_cycles = 400;  // receiver holds off, input backs up
      phase_items = (phase == 1 || phase == 2) ? 120 : 260;
      for (int n = 0; n < phase_items; n++) send_command(random_command());
      drain();
      // Cycle the capacity through small, full and oversize settings.
      case (phase)
        0: write_capacity(8);
        1: write_capacity(64);
        2: write_capacity(3);
        3: write_capacity(100);
        default: write_capacity(64);
      endcase
    end

    drain();
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("PASS sorted_grant_table_mask_query_top");
    end else begin
      $display("FAIL sorted_grant_table_mask_query_top");
    end
    $finish;
  end
endmodule
